>>> sv/qalu_pkg.sv
// shared types and constants of the q24.8 fixed-point alu
package qalu_pkg;

    localparam int unsigned FRAC_BITS_DEF = 8;
    localparam int unsigned WORD_W        = 32;

    typedef enum logic [3:0] {
        MODE_ADD     = 4'd0,
        MODE_SUB     = 4'd1,
        MODE_MUL     = 4'd2,
        MODE_DIV     = 4'd3,
        MODE_GT      = 4'd4,
        MODE_LT      = 4'd5,
        MODE_GE      = 4'd6,
        MODE_LE      = 4'd7,
        MODE_EQ      = 4'd8,
        MODE_NE      = 4'd9,
        MODE_MIN     = 4'd10,
        MODE_MAX     = 4'd11,
        MODE_INC     = 4'd12,
        MODE_DEC     = 4'd13,
        MODE_INT2FIX = 4'd14,
        MODE_FIX2INT = 4'd15
    } t_mode;

    typedef struct packed {
        logic valid;
        logic is_div;
        logic neg;
        logic dz;
        logic cmp;
    } t_ctl;

endpackage

>>> sv/qalu_if.sv
// handshake channels of the fixed-point alu
interface qalu_in_if;
    logic                      valid;
    logic                      ready;
    logic [3:0]                mode;
    logic signed [31:0]        operand_a;
    logic signed [31:0]        operand_b;

    modport source (output valid, mode, operand_a, operand_b, input ready);
    modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface qalu_out_if;
    logic                      valid;
    logic                      ready;
    logic signed [31:0]        result_word;
    logic                      compare_true;
    logic                      divide_by_zero;

    modport source (output valid, result_word, compare_true, divide_by_zero, input ready);
    modport sink   (input valid, result_word, compare_true, divide_by_zero, output ready);
endinterface

>>> sv/qalu_front.sv
// decode stage: direct results, product and divider setup
module qalu_front #(
    parameter int unsigned FRAC_BITS = qalu_pkg::FRAC_BITS_DEF,
    localparam int unsigned DW = qalu_pkg::WORD_W + FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [3:0]           i_mode,
    input  logic signed [31:0]   i_a,
    input  logic signed [31:0]   i_b,
    output qalu_pkg::t_ctl       o_ctl,
    output logic [31:0]          o_res,
    output logic [DW-1:0]        o_dvd,
    output logic [31:0]          o_dvs
);

    qalu_pkg::t_ctl      r_ctl, n_ctl;
    logic [31:0]         r_res, n_res;
    logic [DW-1:0]       r_dvd, n_dvd;
    logic [31:0]         r_dvs, n_dvs;
    logic signed [63:0]  prod;
    logic [31:0]         mag_a, mag_b;

    assign prod  = i_a * i_b;
    assign mag_a = i_a[31] ? 32'(-i_a) : 32'(i_a);
    assign mag_b = i_b[31] ? 32'(-i_b) : 32'(i_b);

    always_comb begin
        n_ctl        = '0;
        n_ctl.valid  = i_valid;
        n_res        = '0;
        n_dvd        = {mag_a, FRAC_BITS'(0)};
        n_dvs        = mag_b;
        unique case (qalu_pkg::t_mode'(i_mode))
            qalu_pkg::MODE_ADD:     n_res = 32'(i_a + i_b);
            qalu_pkg::MODE_SUB:     n_res = 32'(i_a - i_b);
            qalu_pkg::MODE_MUL:     n_res = prod[FRAC_BITS+31:FRAC_BITS];
            qalu_pkg::MODE_DIV: begin
                n_ctl.is_div = 1'b1;
                n_ctl.neg    = i_a[31] ^ i_b[31];
                n_ctl.dz     = (i_b == 32'sd0);
            end
            qalu_pkg::MODE_GT:      n_ctl.cmp = (i_a > i_b);
            qalu_pkg::MODE_LT:      n_ctl.cmp = (i_a < i_b);
            qalu_pkg::MODE_GE:      n_ctl.cmp = (i_a >= i_b);
            qalu_pkg::MODE_LE:      n_ctl.cmp = (i_a <= i_b);
            qalu_pkg::MODE_EQ:      n_ctl.cmp = (i_a == i_b);
            qalu_pkg::MODE_NE:      n_ctl.cmp = (i_a != i_b);
            qalu_pkg::MODE_MIN:     n_res = (i_a < i_b) ? i_a : i_b;
            qalu_pkg::MODE_MAX:     n_res = (i_a > i_b) ? i_a : i_b;
            qalu_pkg::MODE_INC:     n_res = 32'(i_a + 32'sd1);
            qalu_pkg::MODE_DEC:     n_res = 32'(i_a - 32'sd1);
            qalu_pkg::MODE_INT2FIX: n_res = 32'(i_a <<< FRAC_BITS);
            qalu_pkg::MODE_FIX2INT: n_res = 32'(i_a >>> FRAC_BITS);
            default:                n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
            r_dvd <= n_dvd;
            r_dvs <= n_dvs;
        end
    end

    assign o_ctl = r_ctl;
    assign o_res = r_res;
    assign o_dvd = r_dvd;
    assign o_dvs = r_dvs;

endmodule

>>> sv/qalu_div_cell.sv
// one restoring division cell: one quotient bit per word
module qalu_div_cell #(
    parameter int unsigned FRAC_BITS = qalu_pkg::FRAC_BITS_DEF,
    localparam int unsigned DW = qalu_pkg::WORD_W + FRAC_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  qalu_pkg::t_ctl  i_ctl,
    input  logic [31:0]     i_res,
    input  logic [DW-1:0]   i_dvd,
    input  logic [31:0]     i_dvs,
    input  logic [31:0]     i_rem,
    input  logic [DW-1:0]   i_quo,
    output qalu_pkg::t_ctl  o_ctl,
    output logic [31:0]     o_res,
    output logic [DW-1:0]   o_dvd,
    output logic [31:0]     o_dvs,
    output logic [31:0]     o_rem,
    output logic [DW-1:0]   o_quo
);

    qalu_pkg::t_ctl  r_ctl;
    logic [31:0]     r_res, r_dvs, r_rem, n_rem;
    logic [DW-1:0]   r_dvd, r_quo;
    logic [32:0]     shifted;
    logic [33:0]     trial;
    logic            fits;

    assign shifted = {i_rem, i_dvd[DW-1]};
    assign trial   = {1'b0, shifted} - {2'b00, i_dvs};
    assign fits    = ~trial[33];
    assign n_rem   = fits ? trial[31:0] : shifted[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= i_res;
            r_dvs <= i_dvs;
            r_rem <= n_rem;
            r_dvd <= {i_dvd[DW-2:0], 1'b0};
            r_quo <= {i_quo[DW-2:0], fits};
        end
    end

    assign o_ctl = r_ctl;
    assign o_res = r_res;
    assign o_dvd = r_dvd;
    assign o_dvs = r_dvs;
    assign o_rem = r_rem;
    assign o_quo = r_quo;

endmodule

>>> sv/fixed_point_q24_8_alu_unit.sv
// top level of the q24.8 fixed-point alu
// every mode takes the same path: front stage, row of division cells, output register
// throughput: one word per cycle while the output is not held, set by the row of one-bit division cells
// the whole pipe holds only while a finished word waits at the output
// reset (synchronous, active low) clears all valid flags; payload is not reset
module fixed_point_q24_8_alu_unit #(
    parameter int unsigned FRAC_BITS = qalu_pkg::FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qalu_in_if.sink    i_in,
    qalu_out_if.source o_out
);

    localparam int unsigned DW = qalu_pkg::WORD_W + FRAC_BITS;

    qalu_pkg::t_ctl  ctl_c [DW+1];
    logic [31:0]     res_c [DW+1];
    logic [DW-1:0]   dvd_c [DW+1];
    logic [31:0]     dvs_c [DW+1];
    logic [31:0]     rem_c [DW+1];
    logic [DW-1:0]   quo_c [DW+1];

    qalu_pkg::t_ctl  r_o_ctl;
    logic [31:0]     r_o_res, n_o_res;
    logic            en;

    assign en         = !(r_o_ctl.valid && !o_out.ready);
    assign i_in.ready = en;

    qalu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_mode  (i_in.mode),
        .i_a     (i_in.operand_a),
        .i_b     (i_in.operand_b),
        .o_ctl   (ctl_c[0]),
        .o_res   (res_c[0]),
        .o_dvd   (dvd_c[0]),
        .o_dvs   (dvs_c[0])
    );

    assign rem_c[0] = '0;
    assign quo_c[0] = '0;

    for (genvar g = 0; g < DW; g++) begin : g_cell
        qalu_div_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (ctl_c[g]),
            .i_res   (res_c[g]),
            .i_dvd   (dvd_c[g]),
            .i_dvs   (dvs_c[g]),
            .i_rem   (rem_c[g]),
            .i_quo   (quo_c[g]),
            .o_ctl   (ctl_c[g+1]),
            .o_res   (res_c[g+1]),
            .o_dvd   (dvd_c[g+1]),
            .o_dvs   (dvs_c[g+1]),
            .o_rem   (rem_c[g+1]),
            .o_quo   (quo_c[g+1])
        );
    end

    always_comb begin
        priority if (!ctl_c[DW].is_div) begin
            n_o_res = res_c[DW];
        end else if (ctl_c[DW].dz) begin
            n_o_res = '0;
        end else if (ctl_c[DW].neg) begin
            n_o_res = 32'(-quo_c[DW][31:0]);
        end else begin
            n_o_res = quo_c[DW][31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_ctl <= '0;
        end else if (en) begin
            r_o_ctl <= ctl_c[DW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_res <= n_o_res;
        end
    end

    assign o_out.valid          = r_o_ctl.valid;
    assign o_out.result_word    = r_o_res;
    assign o_out.compare_true   = r_o_ctl.cmp;
    assign o_out.divide_by_zero = r_o_ctl.dz;

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.divide_by_zero |-> o_out.result_word == 32'sd0)
        else $error("divide by zero word carries a nonzero result");

    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.compare_true |-> o_out.result_word == 32'sd0)
        else $error("true comparison carries a nonzero result");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.compare_true && o_out.divide_by_zero))
        else $error("compare and divide by zero flags both set");

    a_dz_is_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_ctl.dz |-> r_o_ctl.is_div)
        else $error("divide by zero flag on a non-divide word");

endmodule

>>> test/qalu_checker.sv
// checker that predicts and compares the words of the fixed-point alu
module qalu_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    qalu_in_if.sink       i_in,
    qalu_out_if.sink      i_out,
    output int            o_errors,
    output int            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = qalu_pkg::FRAC_BITS_DEF;

    typedef struct packed {
        logic [31:0] word;
        logic        cmp;
        logic        dz;
    } t_alu_word;

    t_alu_word alu_words_due[$];

    function automatic t_alu_word alu_predict(logic [3:0] m, logic signed [31:0] a,
                                              logic signed [31:0] b);
        t_alu_word r;
        logic signed [63:0] a64;
        logic signed [63:0] b64;
        logic signed [63:0] p;
        logic [63:0] un;
        logic [63:0] ud;
        logic [63:0] q;
        a64 = a;
        b64 = b;
        r = '0;
        case (qalu_pkg::t_mode'(m))
            qalu_pkg::MODE_ADD: r.word = a + b;
            qalu_pkg::MODE_SUB: r.word = a - b;
            qalu_pkg::MODE_MUL: begin
                p = a64 * b64;
                r.word = 32'(p >>> FB);
            end
            qalu_pkg::MODE_DIV: begin
                if (b == 0) begin
                    r.dz = 1'b1;
                end else begin
                    p = a64 <<< FB;
                    un = p < 0 ? -p : p;
                    ud = b64 < 0 ? -b64 : b64;
                    q = un / ud;
                    r.word = 32'(((p < 0) != (b64 < 0)) ? -q : q);
                end
            end
            qalu_pkg::MODE_GT: r.cmp = a > b;
            qalu_pkg::MODE_LT: r.cmp = a < b;
            qalu_pkg::MODE_GE: r.cmp = a >= b;
            qalu_pkg::MODE_LE: r.cmp = a <= b;
            qalu_pkg::MODE_EQ: r.cmp = a == b;
            qalu_pkg::MODE_NE: r.cmp = a != b;
            qalu_pkg::MODE_MIN: r.word = (a < b) ? a : b;
            qalu_pkg::MODE_MAX: r.word = (a > b) ? a : b;
            qalu_pkg::MODE_INC: r.word = a + 32'sd1;
            qalu_pkg::MODE_DEC: r.word = a - 32'sd1;
            qalu_pkg::MODE_INT2FIX: r.word = a << FB;
            default: r.word = a >>> FB;
        endcase
        return r;
    endfunction

    assign o_pending = alu_words_due.size();

    always @(posedge i_clk) begin
        t_alu_word want;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_in.valid && i_in.ready)
                alu_words_due.push_back(alu_predict(i_in.mode, i_in.operand_a, i_in.operand_b));
            if (i_out.valid && i_out.ready) begin
                if (alu_words_due.size() == 0) begin
                    $display("%0t: unexpected word %h", $realtime, i_out.result_word);
                    o_errors <= o_errors + 1;
                end else begin
                    want = alu_words_due.pop_front();
                    if (want.word !== i_out.result_word || want.cmp !== i_out.compare_true
                        || want.dz !== i_out.divide_by_zero) begin
                        $display("%0t: expected %h/%b/%b actual %h/%b/%b", $realtime,
                                 want.word, want.cmp, want.dz, i_out.result_word,
                                 i_out.compare_true, i_out.divide_by_zero);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

>>> test/testbench.sv
// stimulus and verdict for the fixed-point alu
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors;
    int   pending;

    qalu_in_if  in_ch ();
    qalu_out_if out_ch ();

    fixed_point_q24_8_alu_unit dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch));
    qalu_checker chk (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_out(out_ch),
                      .o_errors(errors), .o_pending(pending));

    always #1 i_clk = ~i_clk;

    bit calm;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.mode = '0;
        in_ch.operand_a = '0;
        in_ch.operand_b = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        out_ch.ready <= calm || ($urandom_range(99) >= 7);
    end

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return $urandom_range(2047) - 1024;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(logic [3:0] m, logic [31:0] a, logic [31:0] b);
        while (!calm && $urandom_range(99) < 7) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode <= m;
        in_ch.operand_a <= a;
        in_ch.operand_b <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    initial begin
        int k;
        logic [31:0] a;
        logic [31:0] b;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (k = 0; k < 16; k++) begin
            send_word(k[3:0], 32'h8000_0000, 32'h7fff_ffff);
        end
        send_word(qalu_pkg::MODE_DIV, 32'h0000_0100, 32'h0);
        send_word(qalu_pkg::MODE_DIV, 32'h8000_0000, 32'hffff_ffff);
        send_word(qalu_pkg::MODE_MUL, 32'h8000_0000, 32'h8000_0000);
        send_word(qalu_pkg::MODE_EQ, 32'h7fff_ffff, 32'h7fff_ffff);
        send_word(qalu_pkg::MODE_FIX2INT, 32'hffff_ff01, 32'h0);
        send_word(qalu_pkg::MODE_INC, 32'h7fff_ffff, 32'hffff_ffff);
        send_word(qalu_pkg::MODE_MIN, 32'h5, 32'h5);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        for (k = 0; k < 2000; k++) begin
            calm = (k >= 800 && k < 1100);
            a = pick_operand();
            b = ($urandom_range(15) == 0) ? pick_operand() & 32'h0 : pick_operand();
            if ($urandom_range(3) == 0) b = a;
            send_word(4'($urandom_range(15)), a, b);
        end
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #200000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
